// File: rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int unsigned TOTAL_ORDER_DEF = 16;
	localparam int unsigned MIN_ORDER_DEF   = 5;

	localparam int unsigned ENTRY_W   = 7;
	localparam int unsigned ORD_W     = 5;
	localparam int unsigned E_VALID_B = 6;
	localparam int unsigned E_ALLOC_B = 5;
	localparam logic [15:0] HDR_BYTES = 16'd16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOFIT   = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;
	localparam logic [1:0] STAT_DOUBLE  = 2'd3;

	localparam logic REG_FIT_MODE = 1'b0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_NEED,
		ST_ORD,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SPLIT_INIT,
		ST_SPLIT,
		ST_AFIN,
		ST_FCHK,
		ST_FENT,
		ST_MRD,
		ST_MCHK,
		ST_MFIN,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RES_ALLOC_OK,
		RES_FREE_OK,
		RES_NOFIT,
		RES_INVALID,
		RES_DOUBLE
	} kind_t;

	typedef struct packed {
		logic  clear_step;
		logic  load;
		logic  mul;
		logic  need_init;
		logic  ord_step;
		logic  scan_init;
		logic  scan_rd;
		logic  scan_chk;
		logic  split_init;
		logic  split_step;
		logic  fchk;
		logic  fent;
		logic  merge_rd;
		logic  merge_step;
		logic  fin_alloc;
		logic  fin_free;
		logic  emit;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_free_op;
		logic ord_fit;
		logic ord_max;
		logic scan_done;
		logic scan_stop;
		logic found;
		logic split_more;
		logic free_bad;
		logic ent_valid;
		logic ent_alloc;
		logic merge_top;
		logic bud_ok;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: one allocate or free item per handshake.
// ----------------------------------------------------------------------------
interface bba_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] element_size;
	logic [15:0] element_count;
	logic [15:0] free_offset;

	modport source (output valid, op, element_size, element_count, free_offset,
		input ready);
	modport sink (input valid, op, element_size, element_count, free_offset,
		output ready);
endinterface

// File: rtl/core/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_offset;
	logic [4:0]  granted_order;
	logic [1:0]  status;

	modport source (output valid, data_offset, granted_order, status, input ready);
	modport sink (input valid, data_offset, granted_order, status, output ready);
endinterface

// File: rtl/core/buddy_block_allocator.sv
// Allocate steps the order up to a fit, walks the block table and splits the
// chosen block; free checks the block entry and merges buddies while they are free.
// One item is in flight at a time; the next is taken once the result is registered.
// After reset a clearing pass over the whole block table runs first;
// no item is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator top: APB config register, sequencer and datapath.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
	parameter int unsigned TOTAL_ORDER = bba_pkg::TOTAL_ORDER_DEF,
	parameter int unsigned MIN_ORDER   = bba_pkg::MIN_ORDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bba_req_if.sink     req,
	bba_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bba_pkg::*;

	logic [1:0] place_rule_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FIT_MODE) ? {30'd0, place_rule_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_rule_q <= FIT_FIRST;
		end else if (psel && penable && pwrite && paddr[2] == REG_FIT_MODE) begin
			place_rule_q <= pwdata[1:0];
		end
	end

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_datapath #(.TOTAL_ORDER(TOTAL_ORDER), .MIN_ORDER(MIN_ORDER)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.place_rule        (place_rule_q),
		.req_op            (req.op),
		.req_element_size  (req.element_size),
		.req_element_count (req.element_count),
		.req_free_offset   (req.free_offset),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_data_offset   (rsp.data_offset),
		.rsp_granted_order (rsp.granted_order),
		.rsp_status        (rsp.status)
	);

`ifndef SYNTHESIS
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result written over a pending response");
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp.valid)
		else $error("emitted result not presented");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !req.ready)
		else $error("item taken during table clear");
	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_OK) |->
		(rsp.granted_order >= 5'(MIN_ORDER) && rsp.granted_order <= 5'(TOTAL_ORDER)))
		else $error("granted order out of range");
`endif
endmodule

// File: rtl/core/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/core/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Block table, size math, fit scan, split and merge address logic, result reg.
// ----------------------------------------------------------------------------
module bba_datapath #(
	parameter int unsigned TOTAL_ORDER = 16,
	parameter int unsigned MIN_ORDER   = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::cmd_t cmd,
	output bba_pkg::sts_t sts,
	input  logic [1:0]    place_rule,
	input  logic          req_op,
	input  logic [15:0]   req_element_size,
	input  logic [15:0]   req_element_count,
	input  logic [15:0]   req_free_offset,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output logic [15:0]   rsp_data_offset,
	output logic [4:0]    rsp_granted_order,
	output logic [1:0]    rsp_status
);
	import bba_pkg::*;

	localparam int unsigned IDX_W = TOTAL_ORDER - MIN_ORDER;
	localparam int unsigned AW    = (IDX_W > 0) ? IDX_W : 1;
	localparam int unsigned DEPTH = 1 << IDX_W;
	localparam int unsigned SW    = AW + 1;
	localparam logic [ORD_W-1:0] MIN_O = ORD_W'(MIN_ORDER);
	localparam logic [ORD_W-1:0] TOT_O = ORD_W'(TOTAL_ORDER);
	localparam logic [15:0] GMASK = 16'((1 << MIN_ORDER) - 1);
	localparam logic [ENTRY_W-1:0] INIT_ENTRY = {1'b1, 1'b0, TOT_O};

	logic [15:0]        size_q, count_q, free_q;
	logic [31:0]        prod_q;
	logic [32:0]        need_q;
	logic [ORD_W-1:0]   ord_q, best_ord_q, sp_q, mo_q;
	logic [SW-1:0]      scan_q;
	logic               found_q;
	logic [AW-1:0]      best_q, idx_q, clr_q;
	logic               out_valid_q;
	logic [15:0]        out_off_q;
	logic [ORD_W-1:0]   out_ord_q;
	logic [1:0]         out_st_q;

	logic               we, re;
	logic [AW-1:0]      waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;

	logic               ent_valid, ent_alloc;
	logic [ORD_W-1:0]   ent_ord;
	logic [SW-1:0]      step;
	logic               cand, take, best_mode, worst_mode;
	logic [15:0]        t;
	logic [24:0]        t_ext, t_sh;
	logic [AW-1:0]      f_idx, bud, split_addr;
	logic [31:0]        alloc_off, free_off;

	bba_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH), .AW(AW)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ent_valid  = rdata[E_VALID_B];
	assign ent_alloc  = rdata[E_ALLOC_B];
	assign ent_ord    = rdata[ORD_W-1:0];
	assign best_mode  = (place_rule == FIT_BEST);
	assign worst_mode = (place_rule == FIT_WORST);

	// blocks tile the region, so the scan hops from block start to block start
	assign step = (ent_valid && ent_ord >= MIN_O && ent_ord <= TOT_O) ?
		(SW'(1) << (ent_ord - MIN_O)) : SW'(1);
	assign cand = ent_valid && !ent_alloc && (ent_ord >= ord_q);
	assign take = cand && (!found_q || (best_mode && ent_ord < best_ord_q) ||
		(worst_mode && ent_ord > best_ord_q));

	assign t     = free_q - HDR_BYTES;
	assign t_ext = {9'd0, t};
	assign t_sh  = t_ext >> MIN_ORDER;
	assign f_idx = t_sh[AW-1:0];

	assign bud        = idx_q ^ (AW'(1) << (mo_q - MIN_O));
	assign split_addr = best_q + (AW'(1) << (sp_q - MIN_O - ORD_W'(1)));
	assign alloc_off  = (32'(best_q) << MIN_ORDER) + 32'(HDR_BYTES);
	assign free_off   = (32'(idx_q) << MIN_ORDER) + 32'(HDR_BYTES);

	always_comb begin
		sts.clear_last = (clr_q == AW'(DEPTH - 1));
		sts.is_free_op = (req_op == OP_FREE);
		sts.ord_fit    = (need_q <= (33'd1 << ord_q));
		sts.ord_max    = (ord_q >= TOT_O);
		sts.scan_done  = (scan_q >= SW'(DEPTH));
		sts.scan_stop  = cand && !found_q && !best_mode && !worst_mode;
		sts.found      = found_q;
		sts.split_more = (sp_q > ord_q);
		sts.free_bad   = (free_q < HDR_BYTES) || (t_ext >= (25'd1 << TOTAL_ORDER)) ||
			((t & GMASK) != 16'd0);
		sts.ent_valid  = ent_valid;
		sts.ent_alloc  = ent_alloc;
		sts.merge_top  = (mo_q >= TOT_O);
		sts.bud_ok     = ent_valid && !ent_alloc && (ent_ord == mo_q);
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	always_comb begin
		re    = 1'b0;
		raddr = scan_q[AW-1:0];
		if (cmd.fchk) begin
			re    = 1'b1;
			raddr = f_idx;
		end else if (cmd.merge_rd) begin
			re    = 1'b1;
			raddr = bud;
		end else if (cmd.scan_rd) begin
			re = 1'b1;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (cmd.clear_step) begin
			we    = 1'b1;
			wdata = (clr_q == '0) ? INIT_ENTRY : '0;
		end else if (cmd.split_step) begin
			we    = 1'b1;
			waddr = split_addr;
			wdata = {1'b1, 1'b0, sp_q - ORD_W'(1)};
		end else if (cmd.merge_step) begin
			// the higher of the pair loses its header
			we    = 1'b1;
			waddr = (bud > idx_q) ? bud : idx_q;
		end else if (cmd.fin_alloc) begin
			we    = 1'b1;
			waddr = best_q;
			wdata = {1'b1, 1'b1, ord_q};
		end else if (cmd.fin_free) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = {1'b1, 1'b0, mo_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (cmd.scan_chk && take) begin
				found_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q  <= req_element_size;
			count_q <= req_element_count;
			free_q  <= req_free_offset;
		end
		if (cmd.mul) begin
			prod_q <= size_q * count_q;
		end
		if (cmd.need_init) begin
			need_q <= {1'b0, prod_q} + 33'(HDR_BYTES);
			ord_q  <= MIN_O;
		end else if (cmd.ord_step) begin
			ord_q <= ord_q + ORD_W'(1);
		end
		if (cmd.scan_init) begin
			scan_q <= '0;
		end else if (cmd.scan_chk) begin
			scan_q <= scan_q + step;
			if (take) begin
				best_q     <= scan_q[AW-1:0];
				best_ord_q <= ent_ord;
			end
		end
		if (cmd.split_init) begin
			sp_q <= best_ord_q;
		end else if (cmd.split_step) begin
			sp_q <= sp_q - ORD_W'(1);
		end
		if (cmd.fchk) begin
			idx_q <= f_idx;
		end else if (cmd.merge_step && bud < idx_q) begin
			idx_q <= bud;
		end
		if (cmd.fent) begin
			mo_q <= (ent_ord < MIN_O) ? MIN_O : ent_ord;
		end else if (cmd.merge_step) begin
			mo_q <= mo_q + ORD_W'(1);
		end
		if (cmd.emit) begin
			case (cmd.kind)
				RES_ALLOC_OK: begin
					out_off_q <= alloc_off[15:0];
					out_ord_q <= ord_q;
					out_st_q  <= STAT_OK;
				end
				RES_FREE_OK: begin
					out_off_q <= free_off[15:0];
					out_ord_q <= mo_q;
					out_st_q  <= STAT_OK;
				end
				RES_NOFIT: begin
					out_off_q <= '0;
					out_ord_q <= '0;
					out_st_q  <= STAT_NOFIT;
				end
				RES_DOUBLE: begin
					out_off_q <= '0;
					out_ord_q <= '0;
					out_st_q  <= STAT_DOUBLE;
				end
				default: begin
					out_off_q <= '0;
					out_ord_q <= '0;
					out_st_q  <= STAT_INVALID;
				end
			endcase
		end
	end

	assign rsp_valid         = out_valid_q;
	assign rsp_data_offset   = out_off_q;
	assign rsp_granted_order = out_ord_q;
	assign rsp_status        = out_st_q;
endmodule

// File: rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, allocate search and split, free check and merge.
// ----------------------------------------------------------------------------
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q  <= RES_NOFIT;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		case (state_q)
			ST_CLEAR: if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) begin
					state_d = sts.is_free_op ? ST_FCHK : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_NEED;
			ST_NEED: state_d = ST_ORD;
			ST_ORD: begin
				if (sts.ord_fit) begin
					state_d = ST_SCAN_RD;
				end else if (sts.ord_max) begin
					kind_d  = RES_NOFIT;
					state_d = ST_EMIT;
				end
			end
			ST_SCAN_RD: begin
				if (sts.scan_done) begin
					if (sts.found) begin
						state_d = ST_SPLIT_INIT;
					end else begin
						kind_d  = RES_NOFIT;
						state_d = ST_EMIT;
					end
				end else begin
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK:   state_d = sts.scan_stop ? ST_SPLIT_INIT : ST_SCAN_RD;
			ST_SPLIT_INIT: state_d = ST_SPLIT;
			ST_SPLIT:      if (!sts.split_more) state_d = ST_AFIN;
			ST_AFIN:       if (sts.out_free) state_d = ST_IDLE;
			ST_FCHK: begin
				if (sts.free_bad) begin
					kind_d  = RES_INVALID;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_FENT;
				end
			end
			ST_FENT: begin
				if (!sts.ent_valid) begin
					kind_d  = RES_INVALID;
					state_d = ST_EMIT;
				end else if (!sts.ent_alloc) begin
					kind_d  = RES_DOUBLE;
					state_d = ST_EMIT;
				end else begin
					state_d = ST_MRD;
				end
			end
			ST_MRD:  state_d = sts.merge_top ? ST_MFIN : ST_MCHK;
			ST_MCHK: state_d = sts.bud_ok ? ST_MRD : ST_MFIN;
			ST_MFIN: if (sts.out_free) state_d = ST_IDLE;
			ST_EMIT: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.kind  = kind_q;
		req_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_NEED: cmd.need_init = 1'b1;
			ST_ORD: begin
				cmd.scan_init = sts.ord_fit;
				cmd.ord_step  = !sts.ord_fit && !sts.ord_max;
			end
			ST_SCAN_RD:    cmd.scan_rd = !sts.scan_done;
			ST_SCAN_CHK:   cmd.scan_chk = 1'b1;
			ST_SPLIT_INIT: cmd.split_init = 1'b1;
			ST_SPLIT:      cmd.split_step = sts.split_more;
			ST_AFIN: begin
				cmd.fin_alloc = sts.out_free;
				cmd.emit      = sts.out_free;
				cmd.kind      = RES_ALLOC_OK;
			end
			ST_FCHK: cmd.fchk = !sts.free_bad;
			ST_FENT: cmd.fent = sts.ent_valid && sts.ent_alloc;
			ST_MRD:  cmd.merge_rd = !sts.merge_top;
			ST_MCHK: cmd.merge_step = sts.bud_ok;
			ST_MFIN: begin
				cmd.fin_free = sts.out_free;
				cmd.emit     = sts.out_free;
				cmd.kind     = RES_FREE_OK;
			end
			ST_EMIT: cmd.emit = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
